// ===== rtl/core/alclk_pkg.sv =====
// Package with the shared types and constants of the three-alarm clock.
`default_nettype none

package alclk_pkg;

  typedef enum logic [1:0] {
    OP_TIME_TICK  = 2'd0,
    OP_BLINK_TICK = 2'd1,
    OP_KEY_PRESS  = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KEY_SELECT    = 2'd0,
    KEY_ENABLE    = 2'd1,
    KEY_INCREMENT = 2'd2,
    KEY_VIEW      = 2'd3
  } key_t;

  typedef enum logic [1:0] {
    MODE_RUN         = 2'd0,
    MODE_SET_HOURS   = 2'd1,
    MODE_SET_MINUTES = 2'd2,
    MODE_SET_SECONDS = 2'd3
  } mode_t;

  localparam logic [1:0] CFG_TICKS_PER_SECOND  = 2'd0;
  localparam logic [1:0] CFG_BLINK_HALF_PERIOD = 2'd1;
  localparam logic [1:0] CFG_BEEP_HALF_PERIOD  = 2'd2;

  localparam logic [7:0] TICKS_PER_SECOND_RESET  = 8'd20;
  localparam logic [7:0] BLINK_HALF_PERIOD_RESET = 8'd10;
  localparam logic [7:0] BEEP_HALF_PERIOD_RESET  = 8'd5;

  localparam logic [4:0] HOURS_PER_DAY      = 5'd24;
  localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
  localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
  localparam logic [4:0] HOURS_RESET        = 5'd12;

  localparam logic [2:0] BLANK_NONE    = 3'b000;
  localparam logic [2:0] BLANK_HOURS   = 3'b001;
  localparam logic [2:0] BLANK_MINUTES = 3'b010;
  localparam logic [2:0] BLANK_SECONDS = 3'b100;

  typedef struct packed {
    logic [7:0] ticks_per_second;
    logic [7:0] blink_half_period;
    logic [7:0] beep_half_period;
  } cfg_t;

  typedef struct packed {
    op_t  op;
    key_t which_key;
  } step_t;

  typedef struct packed {
    logic [4:0] shown_hours;
    logic [5:0] shown_minutes;
    logic [5:0] shown_seconds;
    logic [2:0] blank_mask;
    logic       beep_on;
    logic       alarm_enable;
    logic [1:0] view_index;
    logic [1:0] set_mode;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/alclk_if.sv =====
// Handshake interfaces for the item, result and register write channels.
`default_nettype none

interface alclk_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [1:0] which_key;

  modport source (output valid, output op, output which_key, input ready);
  modport sink (input valid, input op, input which_key, output ready);
endinterface

interface alclk_result_if;
  logic       valid;
  logic       ready;
  logic [4:0] shown_hours;
  logic [5:0] shown_minutes;
  logic [5:0] shown_seconds;
  logic [2:0] blank_mask;
  logic       beep_on;
  logic       alarm_enable;
  logic [1:0] view_index;
  logic [1:0] set_mode;

  modport source (
    output valid, output shown_hours, output shown_minutes, output shown_seconds,
    output blank_mask, output beep_on, output alarm_enable, output view_index,
    output set_mode, input ready
  );
  modport sink (
    input valid, input shown_hours, input shown_minutes, input shown_seconds,
    input blank_mask, input beep_on, input alarm_enable, input view_index,
    input set_mode, output ready
  );
endinterface

interface alclk_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/alclk_core.sv =====
// Clock, alarm, blink and beep state registers with their next-state logic.
`default_nettype none

module alclk_core #(
  parameter int NUM_ALARMS = 3
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  advance,
  input  alclk_pkg::step_t     step,
  input  alclk_pkg::cfg_t      cfg,
  output logic [4:0]           hours_next,
  output logic [5:0]           minutes_next,
  output logic [5:0]           seconds_next,
  output alclk_pkg::mode_t     mode_next,
  output logic [1:0]           view_next,
  output logic                 enable_next,
  output logic [4:0]           alarm_hours_next [NUM_ALARMS],
  output logic [5:0]           alarm_minutes_next [NUM_ALARMS],
  output logic                 alarm_edit_next [NUM_ALARMS],
  output logic                 blink_phase_next,
  output logic                 beep_phase_next
);
  import alclk_pkg::*;

  localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam logic [1:0] VIEW_MAX = 2'(NUM_ALARMS);

  logic [7:0] tick_count;
  logic [4:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds;
  mode_t      mode;
  logic [1:0] view;
  logic       enable;
  logic [4:0] alarm_hours [NUM_ALARMS];
  logic [5:0] alarm_minutes [NUM_ALARMS];
  logic       alarm_edit [NUM_ALARMS];
  logic [7:0] blink_count;
  logic       blink_phase;
  logic [7:0] beep_count;
  logic       beep_phase;

  logic [7:0] tick_count_next;
  logic [7:0] blink_count_next;
  logic [7:0] beep_count_next;

  logic [7:0] tick_inc;
  logic [7:0] blink_inc;
  logic [7:0] beep_inc;
  logic [5:0] sec_inc;
  logic [5:0] min_inc;
  logic [4:0] hour_inc;
  logic [5:0] sec_wrap;
  logic [5:0] min_wrap;
  logic [4:0] hour_wrap;
  logic       view_alarm;
  logic [IDX_W-1:0] sel;

  always_comb begin
    tick_inc   = tick_count + 8'd1;
    blink_inc  = blink_count + 8'd1;
    beep_inc   = beep_count + 8'd1;
    sec_inc    = seconds + 6'd1;
    min_inc    = minutes + 6'd1;
    hour_inc   = hours + 5'd1;
    sec_wrap   = (sec_inc >= SECONDS_PER_MINUTE) ? 6'd0 : sec_inc;
    min_wrap   = (min_inc >= MINUTES_PER_HOUR) ? 6'd0 : min_inc;
    hour_wrap  = (hour_inc >= HOURS_PER_DAY) ? 5'd0 : hour_inc;
    view_alarm = (view != 2'd0) && (view <= VIEW_MAX);
    sel        = IDX_W'(view - 2'd1);

    tick_count_next  = tick_count;
    hours_next       = hours;
    minutes_next     = minutes;
    seconds_next     = seconds;
    mode_next        = mode;
    view_next        = view;
    enable_next      = enable;
    blink_count_next = blink_count;
    blink_phase_next = blink_phase;
    beep_count_next  = beep_count;
    beep_phase_next  = beep_phase;
    for (int i = 0; i < NUM_ALARMS; i++) begin
      alarm_hours_next[i]   = alarm_hours[i];
      alarm_minutes_next[i] = alarm_minutes[i];
      alarm_edit_next[i]    = alarm_edit[i];
    end

    unique case (step.op)
      OP_TIME_TICK: begin
        if (mode == MODE_RUN) begin
          if (tick_inc >= cfg.ticks_per_second) begin
            tick_count_next = 8'd0;
            seconds_next    = sec_wrap;
            if (sec_wrap == 6'd0) begin
              minutes_next = min_wrap;
              if (min_wrap == 6'd0) begin
                hours_next = hour_wrap;
              end
            end
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      OP_BLINK_TICK: begin
        if (blink_inc >= cfg.blink_half_period) begin
          blink_count_next = 8'd0;
          blink_phase_next = ~blink_phase;
        end else begin
          blink_count_next = blink_inc;
        end
        if (beep_inc >= cfg.beep_half_period) begin
          beep_count_next = 8'd0;
          beep_phase_next = ~beep_phase;
        end else begin
          beep_count_next = beep_inc;
        end
      end
      OP_KEY_PRESS: begin
        unique case (step.which_key)
          KEY_SELECT: begin
            if (view == 2'd0) begin
              mode_next = mode_t'(mode + 2'd1);
            end else if (view_alarm && mode == MODE_RUN) begin
              for (int i = 0; i < NUM_ALARMS; i++) begin
                if (sel == IDX_W'(i)) begin
                  alarm_edit_next[i] = ~alarm_edit[i];
                end
              end
            end
          end
          KEY_ENABLE: begin
            enable_next = ~enable;
          end
          KEY_INCREMENT: begin
            if (view == 2'd0) begin
              unique case (mode)
                MODE_SET_HOURS:   hours_next = hour_wrap;
                MODE_SET_MINUTES: minutes_next = min_wrap;
                MODE_SET_SECONDS: seconds_next = sec_wrap;
                MODE_RUN: begin
                end
              endcase
            end else if (view_alarm && mode == MODE_RUN) begin
              for (int i = 0; i < NUM_ALARMS; i++) begin
                if (sel == IDX_W'(i)) begin
                  if (alarm_edit[i]) begin
                    alarm_minutes_next[i] = (alarm_minutes[i] + 6'd1 >= MINUTES_PER_HOUR) ?
                                            6'd0 : alarm_minutes[i] + 6'd1;
                  end else begin
                    alarm_hours_next[i] = (alarm_hours[i] + 5'd1 >= HOURS_PER_DAY) ?
                                          5'd0 : alarm_hours[i] + 5'd1;
                  end
                end
              end
            end
          end
          KEY_VIEW: begin
            if (mode == MODE_RUN) begin
              view_next = (view >= VIEW_MAX) ? 2'd0 : view + 2'd1;
            end
          end
        endcase
      end
      OP_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= 8'd0;
      hours       <= HOURS_RESET;
      minutes     <= 6'd0;
      seconds     <= 6'd0;
      mode        <= MODE_RUN;
      view        <= 2'd0;
      enable      <= 1'b0;
      blink_count <= 8'd0;
      blink_phase <= 1'b0;
      beep_count  <= 8'd0;
      beep_phase  <= 1'b0;
      for (int i = 0; i < NUM_ALARMS; i++) begin
        alarm_hours[i]   <= 5'd0;
        alarm_minutes[i] <= 6'd0;
        alarm_edit[i]    <= 1'b0;
      end
    end else if (advance) begin
      tick_count  <= tick_count_next;
      hours       <= hours_next;
      minutes     <= minutes_next;
      seconds     <= seconds_next;
      mode        <= mode_next;
      view        <= view_next;
      enable      <= enable_next;
      blink_count <= blink_count_next;
      blink_phase <= blink_phase_next;
      beep_count  <= beep_count_next;
      beep_phase  <= beep_phase_next;
      for (int i = 0; i < NUM_ALARMS; i++) begin
        alarm_hours[i]   <= alarm_hours_next[i];
        alarm_minutes[i] <= alarm_minutes_next[i];
        alarm_edit[i]    <= alarm_edit_next[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/alclk_display.sv =====
// Display selection, blink blanking and alarm match for one result.
`default_nettype none

module alclk_display #(
  parameter int NUM_ALARMS = 3
) (
  input  wire  [4:0]          hours,
  input  wire  [5:0]          minutes,
  input  wire  [5:0]          seconds,
  input  alclk_pkg::mode_t    mode,
  input  wire  [1:0]          view,
  input  wire                 enable,
  input  wire  [4:0]          alarm_hours [NUM_ALARMS],
  input  wire  [5:0]          alarm_minutes [NUM_ALARMS],
  input  wire                 alarm_edit [NUM_ALARMS],
  input  wire                 blink_phase,
  input  wire                 beep_phase,
  output alclk_pkg::result_t  res
);
  import alclk_pkg::*;

  localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam logic [1:0] VIEW_MAX = 2'(NUM_ALARMS);

  logic             view_alarm;
  logic [IDX_W-1:0] sel;
  logic             match;
  logic [4:0]       sh;
  logic [5:0]       sm;
  logic             edit_minute;
  logic [2:0]       mask;

  always_comb begin
    view_alarm  = (view != 2'd0) && (view <= VIEW_MAX);
    sel         = IDX_W'(view - 2'd1);
    sh          = hours;
    sm          = minutes;
    edit_minute = 1'b0;
    match       = 1'b0;
    for (int i = 0; i < NUM_ALARMS; i++) begin
      if (view_alarm && sel == IDX_W'(i)) begin
        sh          = alarm_hours[i];
        sm          = alarm_minutes[i];
        edit_minute = alarm_edit[i];
      end
      if (alarm_hours[i] == hours && alarm_minutes[i] == minutes) begin
        match = 1'b1;
      end
    end

    mask = BLANK_NONE;
    if (!blink_phase) begin
      if (view_alarm) begin
        mask = edit_minute ? BLANK_MINUTES : BLANK_HOURS;
      end else if (view == 2'd0) begin
        unique case (mode)
          MODE_SET_HOURS:   mask = BLANK_HOURS;
          MODE_SET_MINUTES: mask = BLANK_MINUTES;
          MODE_SET_SECONDS: mask = BLANK_SECONDS;
          MODE_RUN:         mask = BLANK_NONE;
        endcase
      end
    end

    res.shown_hours   = sh;
    res.shown_minutes = sm;
    res.shown_seconds = seconds;
    res.blank_mask    = mask;
    res.beep_on       = enable && match && !beep_phase;
    res.alarm_enable  = enable;
    res.view_index    = view;
    res.set_mode      = mode;
  end

endmodule

`default_nettype wire

// ===== rtl/core/alarm_clock_three_alarms.sv =====
// Top level of the 24-hour clock with shared-enable alarms.
// An accepted input transaction is held in the input register; its result is then captured in the result register.
// Throughput: one transaction per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when the result is not taken.
// Reset (rst, synchronous): clock at 12:00:00, run mode, clock view, alarms at 00:00
// and disabled, counters cleared, registers at 20, 10 and 5.
`default_nettype none

module alarm_clock_three_alarms #(
  parameter int NUM_ALARMS = 3
) (
  input  wire             clk,
  input  wire             rst,
  alclk_item_if.sink      item,
  alclk_result_if.source  result,
  alclk_cfg_if.sink       cfg
);
  import alclk_pkg::*;

  cfg_t    ctrl;
  logic    s1_valid;
  step_t   s1_step;
  logic    out_valid;
  result_t out_data;

  logic    s2_ready;
  logic    advance;
  result_t res;

  logic [4:0] hours_next;
  logic [5:0] minutes_next;
  logic [5:0] seconds_next;
  mode_t      mode_next;
  logic [1:0] view_next;
  logic       enable_next;
  logic [4:0] alarm_hours_next [NUM_ALARMS];
  logic [5:0] alarm_minutes_next [NUM_ALARMS];
  logic       alarm_edit_next [NUM_ALARMS];
  logic       blink_phase_next;
  logic       beep_phase_next;

  assign cfg.ready  = 1'b1;
  assign s2_ready   = !out_valid || result.ready;
  assign item.ready = !s1_valid || s2_ready;
  assign advance    = s1_valid && s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.ticks_per_second  <= TICKS_PER_SECOND_RESET;
      ctrl.blink_half_period <= BLINK_HALF_PERIOD_RESET;
      ctrl.beep_half_period  <= BEEP_HALF_PERIOD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_TICKS_PER_SECOND:  ctrl.ticks_per_second <= cfg.data;
        CFG_BLINK_HALF_PERIOD: ctrl.blink_half_period <= cfg.data;
        CFG_BEEP_HALF_PERIOD:  ctrl.beep_half_period <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_step.op        <= op_t'(item.op);
      s1_step.which_key <= key_t'(item.which_key);
    end
  end

  alclk_core #(
    .NUM_ALARMS(NUM_ALARMS)
  ) u_core (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .step              (s1_step),
    .cfg               (ctrl),
    .hours_next        (hours_next),
    .minutes_next      (minutes_next),
    .seconds_next      (seconds_next),
    .mode_next         (mode_next),
    .view_next         (view_next),
    .enable_next       (enable_next),
    .alarm_hours_next  (alarm_hours_next),
    .alarm_minutes_next(alarm_minutes_next),
    .alarm_edit_next   (alarm_edit_next),
    .blink_phase_next  (blink_phase_next),
    .beep_phase_next   (beep_phase_next)
  );

  alclk_display #(
    .NUM_ALARMS(NUM_ALARMS)
  ) u_display (
    .hours        (hours_next),
    .minutes      (minutes_next),
    .seconds      (seconds_next),
    .mode         (mode_next),
    .view         (view_next),
    .enable       (enable_next),
    .alarm_hours  (alarm_hours_next),
    .alarm_minutes(alarm_minutes_next),
    .alarm_edit   (alarm_edit_next),
    .blink_phase  (blink_phase_next),
    .beep_phase   (beep_phase_next),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  assign result.valid         = out_valid;
  assign result.shown_hours   = out_data.shown_hours;
  assign result.shown_minutes = out_data.shown_minutes;
  assign result.shown_seconds = out_data.shown_seconds;
  assign result.blank_mask    = out_data.blank_mask;
  assign result.beep_on       = out_data.beep_on;
  assign result.alarm_enable  = out_data.alarm_enable;
  assign result.view_index    = out_data.view_index;
  assign result.set_mode      = out_data.set_mode;

  // A stalled transaction in the input register waits there unchanged.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_step))
    else $error("input register lost or changed a stalled transaction");

  // Shown time fields stay inside their ranges.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.shown_hours < HOURS_PER_DAY) &&
                  (out_data.shown_minutes < MINUTES_PER_HOUR) &&
                  (out_data.shown_seconds < SECONDS_PER_MINUTE))
    else $error("shown time field out of range");

  // A set mode is only entered from the clock view, and the view cannot move in a set mode.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.set_mode != MODE_RUN) |-> (out_data.view_index == 2'd0))
    else $error("set mode active outside the clock view");

  // At most one digit pair blinks at a time.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(out_data.blank_mask))
    else $error("more than one pair blanked");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for the three-alarm clock with every display predicted and checked.
`timescale 1ns / 1ps

module testbench;
  import alclk_pkg::*;

  localparam int ALARM_COUNT = 3;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 165;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 1000;

  class alarm_clock_tracker;
    logic [7:0] ticks_per_second;
    logic [7:0] blink_half_period;
    logic [7:0] beep_half_period;
    logic [7:0] tick_count;
    logic [7:0] blink_count;
    logic [7:0] beep_count;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    mode_t      mode;
    logic [1:0] view;
    logic       enable;
    logic       blink_phase;
    logic       beep_phase;
    logic [4:0] alarm_hours [ALARM_COUNT];
    logic [5:0] alarm_minutes [ALARM_COUNT];
    logic       alarm_edit_minute [ALARM_COUNT];
    result_t    pending_displays [$];
    int         mismatch_count;

    function new();
      ticks_per_second = TICKS_PER_SECOND_RESET;
      blink_half_period = BLINK_HALF_PERIOD_RESET;
      beep_half_period = BEEP_HALF_PERIOD_RESET;
      tick_count = '0;
      blink_count = '0;
      beep_count = '0;
      hours = HOURS_RESET;
      minutes = '0;
      seconds = '0;
      mode = MODE_RUN;
      view = '0;
      enable = 1'b0;
      blink_phase = 1'b0;
      beep_phase = 1'b0;
      for (int i = 0; i < ALARM_COUNT; i++) begin
        alarm_hours[i] = '0;
        alarm_minutes[i] = '0;
        alarm_edit_minute[i] = 1'b0;
      end
      mismatch_count = 0;
    endfunction

    function logic [4:0] next_hour(logic [4:0] h);
      return (h + 5'd1 >= HOURS_PER_DAY) ? 5'd0 : h + 5'd1;
    endfunction

    function logic [5:0] next_sixty(logic [5:0] v);
      return (v + 6'd1 >= MINUTES_PER_HOUR) ? 6'd0 : v + 6'd1;
    endfunction

    function bit on_alarm();
      return view >= 2'd1 && view <= ALARM_COUNT;
    endfunction

    function void write_register(logic [1:0] index, logic [7:0] value);
      case (index)
        CFG_TICKS_PER_SECOND: ticks_per_second = value;
        CFG_BLINK_HALF_PERIOD: blink_half_period = value;
        CFG_BEEP_HALF_PERIOD: beep_half_period = value;
        default: ;
      endcase
    endfunction

    function void take_item(op_t op, key_t k);
      int      slot;
      logic    match;
      result_t shown;
      slot = on_alarm() ? int'(view) - 1 : 0;
      case (op)
        OP_TIME_TICK: begin
          if (mode == MODE_RUN) begin
            tick_count = tick_count + 8'd1;
            if (tick_count >= ticks_per_second) begin
              tick_count = '0;
              seconds = next_sixty(seconds);
              if (seconds == 6'd0) begin
                minutes = next_sixty(minutes);
                if (minutes == 6'd0) hours = next_hour(hours);
              end
            end
          end
        end
        OP_BLINK_TICK: begin
          blink_count = blink_count + 8'd1;
          if (blink_count >= blink_half_period) begin
            blink_count = '0;
            blink_phase = ~blink_phase;
          end
          beep_count = beep_count + 8'd1;
          if (beep_count >= beep_half_period) begin
            beep_count = '0;
            beep_phase = ~beep_phase;
          end
        end
        OP_KEY_PRESS: begin
          case (k)
            KEY_SELECT: begin
              if (view == 2'd0) mode = mode_t'(mode + 2'd1);
              else if (on_alarm() && mode == MODE_RUN)
                alarm_edit_minute[slot] = ~alarm_edit_minute[slot];
            end
            KEY_ENABLE: enable = ~enable;
            KEY_INCREMENT: begin
              if (view == 2'd0) begin
                case (mode)
                  MODE_SET_HOURS: hours = next_hour(hours);
                  MODE_SET_MINUTES: minutes = next_sixty(minutes);
                  MODE_SET_SECONDS: seconds = next_sixty(seconds);
                  default: ;
                endcase
              end else if (on_alarm() && mode == MODE_RUN) begin
                if (alarm_edit_minute[slot])
                  alarm_minutes[slot] = next_sixty(alarm_minutes[slot]);
                else
                  alarm_hours[slot] = next_hour(alarm_hours[slot]);
              end
            end
            default: begin
              if (mode == MODE_RUN) view = (view >= ALARM_COUNT) ? 2'd0 : view + 2'd1;
            end
          endcase
        end
        default: ;
      endcase

      shown = '0;
      if (on_alarm()) begin
        slot = int'(view) - 1;
        shown.shown_hours = alarm_hours[slot];
        shown.shown_minutes = alarm_minutes[slot];
        if (!blink_phase) shown.blank_mask = alarm_edit_minute[slot] ? BLANK_MINUTES : BLANK_HOURS;
      end else begin
        shown.shown_hours = hours;
        shown.shown_minutes = minutes;
        if (!blink_phase && view == 2'd0) begin
          case (mode)
            MODE_SET_HOURS: shown.blank_mask = BLANK_HOURS;
            MODE_SET_MINUTES: shown.blank_mask = BLANK_MINUTES;
            MODE_SET_SECONDS: shown.blank_mask = BLANK_SECONDS;
            default: shown.blank_mask = BLANK_NONE;
          endcase
        end
      end
      match = 1'b0;
      for (int i = 0; i < ALARM_COUNT; i++)
        if (alarm_hours[i] == hours && alarm_minutes[i] == minutes) match = 1'b1;
      shown.shown_seconds = seconds;
      shown.beep_on = enable && match && !beep_phase;
      shown.alarm_enable = enable;
      shown.view_index = view;
      shown.set_mode = mode;
      pending_displays.push_back(shown);
    endfunction

    function void report_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    function void compare_display(result_t got);
      result_t want;
      if (pending_displays.size() == 0) begin
        $display("%0t: result transaction with nothing expected, expected none, actual %h",
                 $time, got);
        mismatch_count++;
        return;
      end
      want = pending_displays.pop_front();
      report_field("shown_hours", 8'(want.shown_hours), 8'(got.shown_hours));
      report_field("shown_minutes", 8'(want.shown_minutes), 8'(got.shown_minutes));
      report_field("shown_seconds", 8'(want.shown_seconds), 8'(got.shown_seconds));
      report_field("blank_mask", 8'(want.blank_mask), 8'(got.blank_mask));
      report_field("beep_on", 8'(want.beep_on), 8'(got.beep_on));
      report_field("alarm_enable", 8'(want.alarm_enable), 8'(got.alarm_enable));
      report_field("view_index", 8'(want.view_index), 8'(got.view_index));
      report_field("set_mode", 8'(want.set_mode), 8'(got.set_mode));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   idle_cycles = 0;
  int   tx_gap_pct = 0;
  int   rx_stall_pct = 0;
  int   hold_off_cycles = 0;
  int   sent = 0;
  result_t observed;

  alarm_clock_tracker tracker = new();

  alclk_item_if   item_ch ();
  alclk_result_if result_ch ();
  alclk_cfg_if    cfg_ch ();

  alarm_clock_three_alarms #(.NUM_ALARMS(ALARM_COUNT)) uut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  assign observed = {result_ch.shown_hours, result_ch.shown_minutes, result_ch.shown_seconds,
                     result_ch.blank_mask, result_ch.beep_on, result_ch.alarm_enable,
                     result_ch.view_index, result_ch.set_mode};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) tracker.compare_display(observed);
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic issue(op_t op, key_t k);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.op <= op;
    item_ch.which_key <= k;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    tracker.take_item(op, k);
    sent++;
  endtask

  task automatic press(key_t k);
    issue(OP_KEY_PRESS, k);
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    while (tracker.pending_displays.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_register(logic [1:0] index, logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.write_register(index, value);
  endtask

  task automatic load_settings(logic [7:0] tps, logic [7:0] blink, logic [7:0] beep);
    put_register(CFG_TICKS_PER_SECOND, tps);
    put_register(CFG_BLINK_HALF_PERIOD, blink);
    put_register(CFG_BEEP_HALF_PERIOD, beep);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic show_view(logic [1:0] v);
    if (tracker.view == 2'd0) while (tracker.mode != MODE_RUN) press(KEY_SELECT);
    while (tracker.view != v) press(KEY_VIEW);
  endtask

  task automatic set_clock(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    show_view(2'd0);
    press(KEY_SELECT);
    while (tracker.hours != h) press(KEY_INCREMENT);
    press(KEY_SELECT);
    while (tracker.minutes != m) press(KEY_INCREMENT);
    press(KEY_SELECT);
    while (tracker.seconds != s) press(KEY_INCREMENT);
    press(KEY_SELECT);
  endtask

  task automatic set_alarm(int slot, logic [4:0] h, logic [5:0] m);
    show_view(2'(slot + 1));
    if (tracker.alarm_edit_minute[slot]) press(KEY_SELECT);
    while (tracker.alarm_hours[slot] != h) press(KEY_INCREMENT);
    press(KEY_SELECT);
    while (tracker.alarm_minutes[slot] != m) press(KEY_INCREMENT);
  endtask

  task automatic tick_run(int n, int blink_pct);
    repeat (n) begin
      issue(($urandom_range(0, 99) < blink_pct) ? OP_BLINK_TICK : OP_TIME_TICK,
            key_t'($urandom_range(0, 3)));
    end
  endtask

  task automatic noise(int n);
    repeat (n) issue(op_t'($urandom_range(0, 3)), key_t'($urandom_range(0, 3)));
  endtask

  function automatic logic [4:0] pick_hour();
    return ($urandom_range(0, 2) == 0) ? 5'd23 : 5'($urandom_range(0, 23));
  endfunction

  function automatic logic [5:0] pick_sixty();
    return ($urandom_range(0, 1) == 0) ? 6'($urandom_range(55, 59)) : 6'($urandom_range(0, 59));
  endfunction

  step_t opening [24] = '{
    '{OP_NONE, KEY_VIEW}, '{OP_TIME_TICK, KEY_SELECT}, '{OP_BLINK_TICK, KEY_INCREMENT},
    '{OP_KEY_PRESS, KEY_ENABLE}, '{OP_KEY_PRESS, KEY_SELECT}, '{OP_KEY_PRESS, KEY_INCREMENT},
    '{OP_TIME_TICK, KEY_ENABLE}, '{OP_KEY_PRESS, KEY_VIEW}, '{OP_KEY_PRESS, KEY_SELECT},
    '{OP_KEY_PRESS, KEY_INCREMENT}, '{OP_KEY_PRESS, KEY_SELECT}, '{OP_KEY_PRESS, KEY_INCREMENT},
    '{OP_KEY_PRESS, KEY_SELECT}, '{OP_KEY_PRESS, KEY_INCREMENT}, '{OP_KEY_PRESS, KEY_VIEW},
    '{OP_KEY_PRESS, KEY_INCREMENT}, '{OP_KEY_PRESS, KEY_SELECT}, '{OP_KEY_PRESS, KEY_INCREMENT},
    '{OP_KEY_PRESS, KEY_ENABLE}, '{OP_BLINK_TICK, KEY_VIEW}, '{OP_KEY_PRESS, KEY_VIEW},
    '{OP_KEY_PRESS, KEY_VIEW}, '{OP_KEY_PRESS, KEY_VIEW}, '{OP_NONE, KEY_SELECT}
  };

  logic [7:0] tps_list [PHASES] = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd2, 8'd1};
  logic [7:0] blink_list [PHASES] = '{8'd1, 8'd255, 8'd2, 8'd4, 8'd1, 8'd7};
  logic [7:0] beep_list [PHASES] = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd3, 8'd6};

  initial begin
    int  phase_goal;
    int  slot;
    bit  paused;
    int  rates [3];
    rates = '{0, 10, 35};
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.op <= OP_NONE;
    item_ch.which_key <= KEY_SELECT;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_TICKS_PER_SECOND;
    cfg_ch.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    tx_gap_pct = 20;
    rx_stall_pct = 20;
    foreach (opening[i]) issue(opening[i].op, opening[i].which_key);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 3) begin
        load_settings(8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
                      8'($urandom_range(1, 40)));
      end else begin
        load_settings(tps_list[phase], blink_list[phase], beep_list[phase]);
      end
      if (phase == PHASES - 1) begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct = rates[$urandom_range(0, 2)];
        rx_stall_pct = rates[$urandom_range(0, 2)];
      end
      if (phase == 0 || phase == 3) hold_off_cycles = HOLD_OFF_CYCLES;
      paused = 1'b0;
      phase_goal = sent + PHASE_ITEMS;
      while (sent < phase_goal) begin
        if (phase == 2 && !paused && sent > phase_goal - PHASE_ITEMS / 2) begin
          settle();
          paused = 1'b1;
        end
        case ($urandom_range(0, 9))
          0, 1: begin
            set_clock(pick_hour(), pick_sixty(), pick_sixty());
            tick_run($urandom_range(20, 60), 20);
          end
          2, 3: begin
            slot = $urandom_range(0, ALARM_COUNT - 1);
            if ($urandom_range(0, 1) == 0) set_alarm(slot, tracker.hours, tracker.minutes);
            else set_alarm(slot, pick_hour(), pick_sixty());
            if ($urandom_range(0, 1) == 0) press(KEY_ENABLE);
            if ($urandom_range(0, 1) == 0) show_view(2'd0);
            tick_run($urandom_range(10, 40), 70);
          end
          4, 5: tick_run($urandom_range(10, 40), 40);
          6: begin
            press(KEY_ENABLE);
            tick_run($urandom_range(5, 20), 80);
          end
          default: noise($urandom_range(5, 25));
        endcase
      end
      settle();
    end

    if (tracker.mismatch_count == 0 && tracker.pending_displays.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/alclk_pkg.sv
rtl/core/alclk_if.sv
rtl/core/alclk_core.sv
rtl/core/alclk_display.sv
rtl/core/alarm_clock_three_alarms.sv
dv/testbench.sv
